// ===== src/bnse_pkg.sv =====
// Package for the number-set engine: request codes, controller states and the
// command and status bundles between the controller and the datapath.
// No dependencies.
package bnse_pkg;

  localparam int NUMBER_W = 10;
  localparam int OP_W = 4;
  localparam int WIDX_W = 4;
  localparam int OPND_W = 64;
  localparam int POP_OUT_W = 11;
  localparam logic [POP_OUT_W-1:0] POP_OUT_MAX = 11'd2047;
  localparam int PCNT_W = 7;

  typedef enum logic [OP_W-1:0] {
    OP_ADD     = 4'd0,
    OP_REMOVE  = 4'd1,
    OP_TEST    = 4'd2,
    OP_POP     = 4'd3,
    OP_FNEXT   = 4'd4,
    OP_HIGHEST = 4'd5,
    OP_COUNT   = 4'd6,
    OP_OR      = 4'd7,
    OP_AND     = 4'd8,
    OP_ANDNOT  = 4'd9,
    OP_XOR     = 4'd10,
    OP_COMPARE = 4'd11
  } op_t;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_DIV,
    ST_REM,
    ST_READ,
    ST_APPLY,
    ST_SCAN_START,
    ST_SCAN,
    ST_HIT,
    ST_PCNT,
    ST_POPUPD,
    ST_FINISH
  } state_t;

  typedef struct packed {
    logic load;
    logic do_div;
    logic do_rem;
    logic clr_wr;
    logic rd_target;
    logic apply;
    logic scan_rd;
    logic scan_step;
    logic hit;
    logic pcnt;
    logic popupd;
    logic finish;
  } cmd_t;

  typedef struct packed {
    logic [OP_W-1:0] op;
    logic num_ok;
    logic scan_hit;
    logic scan_end;
    logic clr_last;
  } status_t;

endpackage

// ===== src/bnse_ctrl.sv =====
// Controller state machine of the number-set engine.
// Sequences the datapath through clearing, decode, word access and scans.
// Depends on bnse_pkg.
module bnse_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  output logic              done,
  output bnse_pkg::cmd_t    cmd,
  input  bnse_pkg::status_t st
);

  bnse_pkg::state_t state;
  bnse_pkg::state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= bnse_pkg::ST_CLEAR;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      done  <= (state == bnse_pkg::ST_FINISH);
    end
  end

  always_comb begin
    state_next = state;
    cmd = '0;
    busy = (state != bnse_pkg::ST_IDLE);
    unique case (state)
      bnse_pkg::ST_CLEAR: begin
        cmd.clr_wr = 1'b1;
        if (st.clr_last) begin
          state_next = bnse_pkg::ST_IDLE;
        end
      end
      bnse_pkg::ST_IDLE: begin
        cmd.load = start;
        if (start) begin
          state_next = bnse_pkg::ST_DIV;
        end
      end
      bnse_pkg::ST_DIV: begin
        cmd.do_div = 1'b1;
        state_next = bnse_pkg::ST_REM;
      end
      bnse_pkg::ST_REM: begin
        cmd.do_rem = 1'b1;
        unique case (st.op)
          bnse_pkg::OP_ADD, bnse_pkg::OP_REMOVE, bnse_pkg::OP_TEST: begin
            state_next = st.num_ok ? bnse_pkg::ST_READ : bnse_pkg::ST_FINISH;
          end
          bnse_pkg::OP_OR, bnse_pkg::OP_AND, bnse_pkg::OP_ANDNOT, bnse_pkg::OP_XOR,
          bnse_pkg::OP_COMPARE: begin
            state_next = bnse_pkg::ST_READ;
          end
          bnse_pkg::OP_POP, bnse_pkg::OP_HIGHEST: begin
            state_next = bnse_pkg::ST_SCAN_START;
          end
          bnse_pkg::OP_FNEXT: begin
            state_next = st.num_ok ? bnse_pkg::ST_SCAN_START : bnse_pkg::ST_FINISH;
          end
          default: begin
            state_next = bnse_pkg::ST_FINISH;
          end
        endcase
      end
      bnse_pkg::ST_READ: begin
        cmd.rd_target = 1'b1;
        state_next = bnse_pkg::ST_APPLY;
      end
      bnse_pkg::ST_APPLY: begin
        cmd.apply = 1'b1;
        state_next = bnse_pkg::ST_PCNT;
      end
      bnse_pkg::ST_SCAN_START: begin
        cmd.scan_rd = 1'b1;
        state_next = bnse_pkg::ST_SCAN;
      end
      bnse_pkg::ST_SCAN: begin
        cmd.scan_step = 1'b1;
        priority if (st.scan_hit) begin
          state_next = bnse_pkg::ST_HIT;
        end else if (st.scan_end) begin
          state_next = bnse_pkg::ST_FINISH;
        end else begin
          state_next = bnse_pkg::ST_SCAN;
        end
      end
      bnse_pkg::ST_HIT: begin
        cmd.hit = 1'b1;
        state_next = (st.op == bnse_pkg::OP_POP) ? bnse_pkg::ST_PCNT : bnse_pkg::ST_FINISH;
      end
      bnse_pkg::ST_PCNT: begin
        cmd.pcnt = 1'b1;
        state_next = bnse_pkg::ST_POPUPD;
      end
      bnse_pkg::ST_POPUPD: begin
        cmd.popupd = 1'b1;
        state_next = bnse_pkg::ST_FINISH;
      end
      bnse_pkg::ST_FINISH: begin
        cmd.finish = 1'b1;
        state_next = bnse_pkg::ST_IDLE;
      end
      default: begin
        state_next = bnse_pkg::ST_CLEAR;
      end
    endcase
  end

endmodule

// ===== src/bnse_datapath.sv =====
// Datapath of the number-set engine: the member word memory, the request
// registers, bit search, population tracking and the result registers.
// Depends on bnse_pkg.
module bnse_datapath #(
  parameter int WORD_COUNT = 16,
  parameter int WORD_BITS  = 64
) (
  input  logic                            clk,
  input  logic                            rst,
  input  bnse_pkg::cmd_t                  cmd,
  output bnse_pkg::status_t               st,
  input  logic [bnse_pkg::OP_W-1:0]       operation,
  input  logic [bnse_pkg::NUMBER_W-1:0]   number,
  input  logic [bnse_pkg::WIDX_W-1:0]     word_index,
  input  logic [bnse_pkg::OPND_W-1:0]     operand_word,
  output logic                            found,
  output logic [bnse_pkg::NUMBER_W-1:0]   member_number,
  output logic [bnse_pkg::POP_OUT_W-1:0]  population,
  output logic                            set_empty,
  output logic                            word_equal,
  output logic                            word_disjoint,
  output logic                            word_superset
);

  localparam int AW = (WORD_COUNT > 1) ? $clog2(WORD_COUNT) : 1;
  localparam int BW = $clog2(WORD_BITS);
  localparam int PW = $clog2(WORD_COUNT * WORD_BITS + 1);
  localparam int PWX = (PW > bnse_pkg::POP_OUT_W) ? PW : bnse_pkg::POP_OUT_W;
  localparam int MW = $clog2(WORD_COUNT * WORD_BITS);
  localparam int MWX = (MW > bnse_pkg::NUMBER_W) ? MW : bnse_pkg::NUMBER_W;
  localparam int RSH = 18;
  localparam int RECIP = (2 ** RSH + WORD_BITS - 1) / WORD_BITS;
  localparam int RW = $clog2(RECIP + 1);
  localparam int DW = bnse_pkg::NUMBER_W + RW;
  localparam int NW = bnse_pkg::NUMBER_W;
  localparam int CW = bnse_pkg::PCNT_W;

  function automatic logic [BW-1:0] low_index(input logic [WORD_BITS-1:0] x);
    logic [WORD_BITS-1:0] iso;
    logic [BW-1:0] idx;
    iso = x & (~x + 1'b1);
    idx = '0;
    for (int i = 0; i < WORD_BITS; i++) begin
      if (iso[i]) begin
        idx = idx | BW'(i);
      end
    end
    return idx;
  endfunction

  function automatic logic [BW-1:0] high_index(input logic [WORD_BITS-1:0] x);
    logic [WORD_BITS-1:0] rev;
    for (int i = 0; i < WORD_BITS; i++) begin
      rev[i] = x[WORD_BITS-1-i];
    end
    return BW'(WORD_BITS - 1) - low_index(rev);
  endfunction

  function automatic logic [CW-1:0] pop64(input logic [63:0] x);
    logic [CW-1:0] c [64];
    for (int i = 0; i < 64; i++) begin
      c[i] = CW'(x[i]);
    end
    for (int l = 0; l < 6; l++) begin
      for (int i = 0; i < (32 >> l); i++) begin
        c[i] = c[2*i] + c[2*i+1];
      end
    end
    return c[0];
  endfunction

  logic [bnse_pkg::OP_W-1:0]     req_op;
  logic [NW-1:0]                 req_num;
  logic [bnse_pkg::WIDX_W-1:0]   req_widx;
  logic [WORD_BITS-1:0]          req_opw;
  logic [NW-1:0]                 num_word;
  logic [BW-1:0]                 num_bit;
  logic [AW-1:0]                 target_addr;
  logic                          target_ok;
  logic [AW-1:0]                 scan_addr;
  logic                          scan_first;
  logic                          scan_up;
  logic [AW-1:0]                 clr_addr;
  logic [WORD_BITS-1:0]          mem [WORD_COUNT];
  logic [WORD_BITS-1:0]          rdata;
  logic [WORD_BITS-1:0]          hit_word;
  logic [BW-1:0]                 hit_bit;
  logic [WORD_BITS-1:0]          old_word;
  logic [WORD_BITS-1:0]          new_word;
  logic [CW-1:0]                 pc_old;
  logic [CW-1:0]                 pc_new;
  logic [PW-1:0]                 pop_cnt;
  logic                          res_found;
  logic [MWX-1:0]                res_member;
  logic                          res_eq;
  logic                          res_dis;
  logic                          res_sup;

  logic                          widx_ok;
  logic                          num_ok;
  logic [DW-1:0]                 div_prod;
  logic [NW-1:0]                 nw_scaled;
  logic [NW-1:0]                 num_rem;
  logic [WORD_BITS-1:0]          first_mask;
  logic [WORD_BITS-1:0]          scan_masked;
  logic [AW-1:0]                 scan_next;
  logic                          scan_end;
  logic [WORD_BITS-1:0]          stored;
  logic [WORD_BITS-1:0]          bit_mask;
  logic [WORD_BITS-1:0]          apply_new;
  logic                          op_writes;
  logic [WORD_BITS-1:0]          hit_cleared;
  logic                          wr_en;
  logic [AW-1:0]                 wr_addr;
  logic [WORD_BITS-1:0]          wr_data;
  logic                          rd_en;
  logic [AW-1:0]                 rd_addr;
  logic [PWX-1:0]                pop_x;
  logic [bnse_pkg::POP_OUT_W-1:0] pop_sat;

  assign widx_ok = {7'd0, req_widx} < 11'(WORD_COUNT);
  assign num_ok = {1'b0, num_word} < 11'(WORD_COUNT);
  assign div_prod = DW'(req_num) * DW'(RECIP);
  assign nw_scaled = NW'(num_word * NW'(WORD_BITS));
  assign num_rem = req_num - nw_scaled;

  assign first_mask = (scan_first && scan_up) ? ({WORD_BITS{1'b1}} << num_bit) : '1;
  assign scan_masked = rdata & first_mask;
  assign scan_next = scan_up ? (scan_addr + 1'b1) : (scan_addr - 1'b1);
  assign scan_end = scan_up ? (scan_addr == AW'(WORD_COUNT - 1)) : (scan_addr == '0);

  assign stored = target_ok ? rdata : '0;
  assign bit_mask = WORD_BITS'(1) << num_bit;
  assign hit_cleared = hit_word & ~(WORD_BITS'(1) << hit_bit);

  always_comb begin
    apply_new = stored;
    op_writes = 1'b1;
    unique case (req_op)
      bnse_pkg::OP_ADD:    apply_new = stored | bit_mask;
      bnse_pkg::OP_REMOVE: apply_new = stored & ~bit_mask;
      bnse_pkg::OP_OR:     apply_new = stored | req_opw;
      bnse_pkg::OP_AND:    apply_new = stored & req_opw;
      bnse_pkg::OP_ANDNOT: apply_new = stored & ~req_opw;
      bnse_pkg::OP_XOR:    apply_new = stored ^ req_opw;
      default:             op_writes = 1'b0;
    endcase
  end

  always_comb begin
    wr_en = 1'b0;
    wr_addr = target_addr;
    wr_data = apply_new;
    priority if (cmd.clr_wr) begin
      wr_en = 1'b1;
      wr_addr = clr_addr;
      wr_data = '0;
    end else if (cmd.apply) begin
      wr_en = target_ok && op_writes;
    end else if (cmd.hit) begin
      wr_en = (req_op == bnse_pkg::OP_POP);
      wr_addr = scan_addr;
      wr_data = hit_cleared;
    end else begin
      wr_en = 1'b0;
    end
  end

  always_comb begin
    rd_en = 1'b0;
    rd_addr = target_addr;
    priority if (cmd.rd_target) begin
      rd_en = target_ok;
    end else if (cmd.scan_rd) begin
      rd_en = 1'b1;
      rd_addr = scan_addr;
    end else if (cmd.scan_step) begin
      rd_en = !scan_end;
      rd_addr = scan_next;
    end else begin
      rd_en = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rdata <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_addr <= '0;
      pop_cnt <= '0;
    end else begin
      if (cmd.clr_wr) begin
        clr_addr <= clr_addr + 1'b1;
      end
      if (cmd.popupd) begin
        pop_cnt <= pop_cnt + PW'(pc_new) - PW'(pc_old);
      end
    end
  end

  assign pop_x = PWX'(pop_cnt);
  assign pop_sat = (pop_x > PWX'(bnse_pkg::POP_OUT_MAX)) ? bnse_pkg::POP_OUT_MAX
                                                         : pop_x[bnse_pkg::POP_OUT_W-1:0];

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req_op <= operation;
      req_num <= number;
      req_widx <= word_index;
      req_opw <= operand_word[WORD_BITS-1:0];
      res_found <= 1'b0;
      res_member <= '0;
      res_eq <= 1'b0;
      res_dis <= 1'b0;
      res_sup <= 1'b0;
    end
    if (cmd.do_div) begin
      num_word <= NW'(div_prod >> RSH);
    end
    if (cmd.do_rem) begin
      num_bit <= num_rem[BW-1:0];
      scan_first <= (req_op == bnse_pkg::OP_FNEXT);
      scan_up <= (req_op != bnse_pkg::OP_HIGHEST);
      if (req_op == bnse_pkg::OP_OR || req_op == bnse_pkg::OP_AND ||
          req_op == bnse_pkg::OP_ANDNOT || req_op == bnse_pkg::OP_XOR ||
          req_op == bnse_pkg::OP_COMPARE) begin
        target_addr <= AW'(req_widx);
        target_ok <= widx_ok;
      end else begin
        target_addr <= AW'(num_word);
        target_ok <= num_ok;
      end
      unique case (req_op)
        bnse_pkg::OP_FNEXT:   scan_addr <= AW'(num_word);
        bnse_pkg::OP_HIGHEST: scan_addr <= AW'(WORD_COUNT - 1);
        default:              scan_addr <= '0;
      endcase
    end
    if (cmd.apply) begin
      old_word <= stored;
      new_word <= (target_ok && op_writes) ? apply_new : stored;
      res_found <= (req_op == bnse_pkg::OP_TEST) && target_ok && ((stored & bit_mask) != '0);
      if (req_op == bnse_pkg::OP_COMPARE) begin
        res_eq <= (stored == req_opw);
        res_dis <= ((stored & req_opw) == '0);
        res_sup <= ((req_opw & ~stored) == '0);
      end
    end
    if (cmd.scan_step) begin
      if (scan_masked != '0) begin
        hit_word <= rdata;
        hit_bit <= scan_up ? low_index(scan_masked) : high_index(rdata);
      end else begin
        scan_addr <= scan_next;
        scan_first <= 1'b0;
      end
    end
    if (cmd.hit) begin
      res_found <= 1'b1;
      res_member <= MWX'(scan_addr) * MWX'(WORD_BITS) + MWX'(hit_bit);
      old_word <= hit_word;
      new_word <= hit_cleared;
    end
    if (cmd.pcnt) begin
      pc_old <= pop64(64'(old_word));
      pc_new <= pop64(64'(new_word));
    end
    if (cmd.finish) begin
      found <= res_found;
      member_number <= res_member[NW-1:0];
      population <= pop_sat;
      set_empty <= (pop_cnt == '0);
      word_equal <= res_eq;
      word_disjoint <= res_dis;
      word_superset <= res_sup;
    end
  end

  assign st.op = req_op;
  assign st.num_ok = num_ok;
  assign st.scan_hit = (scan_masked != '0);
  assign st.scan_end = scan_end;
  assign st.clr_last = (clr_addr == AW'(WORD_COUNT - 1));

endmodule

// ===== src/bitset_number_set_engine.sv =====
// Number-set engine top level. A request is decoded in DIV and REM. Word requests and in-range
// add, remove and test then read one word, apply to it and recount it; pop, find-highest and
// in-range find-next scan one stored word per cycle until a hit; pop clears and recounts it.
// Other requests go to FINISH. A new request may be accepted in the cycle done is high;
// one request is in flight at a time. After reset busy stays high while the memory is cleared.
// Results cannot be stalled. Depends on bnse_pkg, bnse_ctrl and bnse_datapath.
module bitset_number_set_engine #(
  parameter int WORD_COUNT = 16,
  parameter int WORD_BITS  = 64
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            start,
  output logic                            busy,
  input  logic [bnse_pkg::OP_W-1:0]       operation,
  input  logic [bnse_pkg::NUMBER_W-1:0]   number,
  input  logic [bnse_pkg::WIDX_W-1:0]     word_index,
  input  logic [bnse_pkg::OPND_W-1:0]     operand_word,
  output logic                            done,
  output logic                            found,
  output logic [bnse_pkg::NUMBER_W-1:0]   member_number,
  output logic [bnse_pkg::POP_OUT_W-1:0]  population,
  output logic                            set_empty,
  output logic                            word_equal,
  output logic                            word_disjoint,
  output logic                            word_superset
);

  bnse_pkg::cmd_t    cmd;
  bnse_pkg::status_t st;

  bnse_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .done  (done),
    .cmd   (cmd),
    .st    (st)
  );

  bnse_datapath #(
    .WORD_COUNT (WORD_COUNT),
    .WORD_BITS  (WORD_BITS)
  ) u_datapath (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .st            (st),
    .operation     (operation),
    .number        (number),
    .word_index    (word_index),
    .operand_word  (operand_word),
    .found         (found),
    .member_number (member_number),
    .population    (population),
    .set_empty     (set_empty),
    .word_equal    (word_equal),
    .word_disjoint (word_disjoint),
    .word_superset (word_superset)
  );

endmodule

// ===== src/bnse_checker.sv =====
// Port-level checker for the number-set engine, bound to the top level.
// Depends on bnse_pkg and bitset_number_set_engine.
module bnse_checker (
  input logic                            clk,
  input logic                            rst,
  input logic                            start,
  input logic                            busy,
  input logic                            done,
  input logic                            found,
  input logic [bnse_pkg::NUMBER_W-1:0]   member_number,
  input logic [bnse_pkg::POP_OUT_W-1:0]  population,
  input logic                            set_empty,
  input logic                            word_equal,
  input logic                            word_disjoint,
  input logic                            word_superset
);

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("busy did not rise after an accepted request");

  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy)
    else $error("result strobe while busy");

  a_empty_pop: assert property (@(posedge clk) disable iff (rst)
    done |-> (set_empty == (population == '0)))
    else $error("empty flag disagrees with population");

  a_missing_zero: assert property (@(posedge clk) disable iff (rst)
    (done && !found) |-> (member_number == '0))
    else $error("member number not zero without a find");

  a_equal_superset: assert property (@(posedge clk) disable iff (rst)
    (done && word_equal) |-> word_superset)
    else $error("equal words not reported as superset");

  a_disjoint_flag: assert property (@(posedge clk) disable iff (rst)
    (done && word_disjoint) |-> !found)
    else $error("disjoint flag together with a find");

endmodule

bind bitset_number_set_engine bnse_checker u_bnse_checker (.*);
